@@ hdl/assert_macros.svh @@
// ---------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros for the row record decoder checkers.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, disabled while reset is asserted
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) prop) else $error(msg);

// Clocked assertion that is also checked during reset
`define ASSERT_CLK_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ hdl/rrd_pkg.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// rrd_pkg
// Types, codes and helper functions shared by the row record decoder.
// ---------------------------------------------------------------------------
package rrd_pkg;

  // Default schema width
  localparam int MAX_COLUMNS_DEF = 16;

  // Depth of the queue between front and back
  localparam int QUEUE_DEPTH = 4;

  // Column type codes
  localparam logic [2:0] TY_INT     = 3'd0;
  localparam logic [2:0] TY_BIGINT  = 3'd1;
  localparam logic [2:0] TY_DOUBLE  = 3'd2;
  localparam logic [2:0] TY_BOOL    = 3'd3;
  localparam logic [2:0] TY_VARCHAR = 3'd4;

  // Result kind codes
  localparam logic [2:0] KIND_INT     = 3'd0;
  localparam logic [2:0] KIND_BIGINT  = 3'd1;
  localparam logic [2:0] KIND_DOUBLE  = 3'd2;
  localparam logic [2:0] KIND_BOOL    = 3'd3;
  localparam logic [2:0] KIND_VC_LEN  = 3'd4;
  localparam logic [2:0] KIND_VC_BYTE = 3'd5;
  localparam logic [2:0] KIND_NULL    = 3'd6;
  localparam logic [2:0] KIND_END     = 3'd7;

  // Record end status codes
  localparam logic [1:0] STAT_OK          = 2'd0;
  localparam logic [1:0] STAT_SHORT_BMAP  = 2'd1;
  localparam logic [1:0] STAT_TRUNC_FIELD = 2'd2;

  // Register indexes (word address bit)
  localparam logic REG_COLUMN_COUNT = 1'b0;
  localparam logic REG_COLUMN_TYPES = 1'b1;

  // Queue entry: byte plus the front's classification
  typedef struct packed {
    logic [7:0] record_byte;
    logic       end_of_record;
    logic       nonzero;
  } qent_t;

  // Live configuration
  typedef struct packed {
    logic [4:0]  column_count;
    logic [47:0] column_types;
  } cfg_t;

  // One result item
  typedef struct packed {
    logic [3:0]  column;
    logic [2:0]  kind;
    logic [63:0] value;
    logic [1:0]  status;
    logic        last;
  } res_t;

  // Type of a column; unknown codes decode as int
  function automatic logic [2:0] col_type(input logic [47:0] types, input logic [3:0] idx);
    logic [2:0] t;
    t = types[3*idx +: 3];
    col_type = (t > TY_VARCHAR) ? TY_INT : t;
  endfunction

  // Field size in bytes for a column type
  function automatic logic [3:0] type_size(input logic [2:0] t);
    logic [3:0] s;
    case (t)
      TY_BIGINT, TY_DOUBLE: s = 4'd8;
      TY_BOOL:              s = 4'd1;
      TY_VARCHAR:           s = 4'd2;
      default:              s = 4'd4;
    endcase
    type_size = s;
  endfunction

endpackage

@@ hdl/rrd_if.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// rrd_if
// Valid/ready channel interfaces for record bytes and decoded results.
// ---------------------------------------------------------------------------

// Record byte channel
interface rrd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] record_byte;
  logic       end_of_record;

  modport source (output valid, output record_byte, output end_of_record, input ready);
  modport sink   (input valid, input record_byte, input end_of_record, output ready);
endinterface

// Result channel
interface rrd_out_if;
  logic        valid;
  logic        ready;
  logic [3:0]  column;
  logic [2:0]  kind;
  logic [63:0] value;
  logic [1:0]  status;
  logic        last;

  modport source (output valid, output column, output kind, output value, output status,
                  output last, input ready);
  modport sink   (input valid, input column, input kind, input value, input status,
                  input last, output ready);
endinterface

@@ hdl/row_record_decoder.sv @@
`timescale 1ns / 1ps
// Throughput: one byte per cycle inside the bitmap or a field while the output
//   is not stalled, with results registered; ending the bitmap (or an empty
//   bitmap) or a column passes a null walk state, and a record end right after a
//   varchar length or text byte result passes an end state. Reset: synchronous
//   active-low rst_n clears the state and config registers, empties the 4-entry
//   queue and returns the row state to bitmap collection; no clearing pass.
// ---------------------------------------------------------------------------
// row_record_decoder
// Null-bitmap row format decoder with APB configuration registers.
// ---------------------------------------------------------------------------
module row_record_decoder #(
  parameter int MAX_COLUMNS = rrd_pkg::MAX_COLUMNS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  rrd_in_if.sink      in_ch,
  rrd_out_if.source   out_ch,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready
);

  logic [4:0]      count_r;
  logic [47:0]     types_r;
  logic            wr_en;
  rrd_pkg::cfg_t   cfg;
  rrd_pkg::qent_t  q_head;
  logic            q_valid, q_pop;
  rrd_pkg::res_t   res;

  // configuration registers
  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      types_r <= '0;
    end else if (wr_en) begin
      unique case (paddr[3])
        rrd_pkg::REG_COLUMN_COUNT: count_r <= pwdata[4:0];
        rrd_pkg::REG_COLUMN_TYPES: types_r <= pwdata[47:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3])
      rrd_pkg::REG_COLUMN_COUNT: prdata = 64'(count_r);
      rrd_pkg::REG_COLUMN_TYPES: prdata = 64'(types_r);
      default:                   prdata = '0;
    endcase
  end

  assign cfg.column_count = count_r;
  assign cfg.column_types = types_r;

  // front: byte queue
  rrd_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_ch.valid),
    .in_ready   (in_ch.ready),
    .in_byte    (in_ch.record_byte),
    .in_eor     (in_ch.end_of_record),
    .head       (q_head),
    .head_valid (q_valid),
    .pop        (q_pop)
  );

  // back: decode engine
  rrd_engine #(
    .MAX_COLUMNS (MAX_COLUMNS)
  ) u_engine (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .q_head    (q_head),
    .q_valid   (q_valid),
    .q_pop     (q_pop),
    .out_res   (res),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready)
  );

  assign out_ch.column = res.column;
  assign out_ch.kind   = res.kind;
  assign out_ch.value  = res.value;
  assign out_ch.status = res.status;
  assign out_ch.last   = res.last;

endmodule

@@ hdl/rrd_queue.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// rrd_queue
// Front end: accepts record bytes, tags them and buffers them for the engine.
// ---------------------------------------------------------------------------
module rrd_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [7:0]        in_byte,
  input  logic              in_eor,
  output rrd_pkg::qent_t    head,
  output logic              head_valid,
  input  logic              pop
);

  localparam int AW = $clog2(rrd_pkg::QUEUE_DEPTH);
  localparam int CW = $clog2(rrd_pkg::QUEUE_DEPTH + 1);

  rrd_pkg::qent_t          mem_r [rrd_pkg::QUEUE_DEPTH];
  logic [AW-1:0]           wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0]           rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]           fill_r, fill_nxt;
  logic                    push;

  assign in_ready   = (fill_r != CW'(rrd_pkg::QUEUE_DEPTH));
  assign push       = in_valid && in_ready;
  assign head       = mem_r[rd_ptr_r];
  assign head_valid = (fill_r != '0);

  // pointer and fill bookkeeping
  always_comb begin
    wr_ptr_nxt = push ? AW'(wr_ptr_r + 1'b1) : wr_ptr_r;
    rd_ptr_nxt = pop  ? AW'(rd_ptr_r + 1'b1) : rd_ptr_r;
    case ({push, pop})
      2'b10:   fill_nxt = CW'(fill_r + 1'b1);
      2'b01:   fill_nxt = CW'(fill_r - 1'b1);
      default: fill_nxt = fill_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      fill_r   <= fill_nxt;
    end
  end

  // entry storage, tagged with a nonzero flag for bool fields
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r].record_byte   <= in_byte;
      mem_r[wr_ptr_r].end_of_record <= in_eor;
      mem_r[wr_ptr_r].nonzero       <= (in_byte != 8'd0);
    end
  end

endmodule

@@ hdl/rrd_engine.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// rrd_engine
// Back end: walks the bitmap, decodes fields and emits at most one result per cycle while the output is not stalled.
// ---------------------------------------------------------------------------
module rrd_engine #(
  parameter int MAX_COLUMNS = rrd_pkg::MAX_COLUMNS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  rrd_pkg::cfg_t     cfg,
  input  rrd_pkg::qent_t    q_head,
  input  logic              q_valid,
  output logic              q_pop,
  output rrd_pkg::res_t     out_res,
  output logic              out_valid,
  input  logic              out_ready
);

  localparam int CIW  = $clog2(MAX_COLUMNS + 1);
  localparam int IDXW = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;

  typedef enum logic [2:0] {
    ST_BYTE = 3'b001,
    ST_WALK = 3'b010,
    ST_END  = 3'b100
  } state_t;

  typedef enum logic [3:0] {
    PH_BITMAP = 4'b0001,
    PH_FIELD  = 4'b0010,
    PH_TEXT   = 4'b0100,
    PH_DONE   = 4'b1000
  } phase_t;

  state_t               st_r, st_nxt;
  phase_t               phase_r, phase_nxt, ph_eff;
  logic [CIW-1:0]       ci_r, ci_nxt, ci_inc;
  logic [3:0]           fbc_r, fbc_nxt, fbc_new;
  logic [63:0]          acc_r, acc_nxt, acc_new;
  logic [MAX_COLUMNS-1:0] null_r, null_nxt;
  logic [15:0]          vrem_r, vrem_nxt, vrem_dec;
  logic [1:0]           bbi_r, bbi_nxt, bbi_inc;
  logic                 pre_r, pre_nxt;
  logic                 pend_r, pend_nxt;
  rrd_pkg::res_t        ores_r, ores_nxt, res;
  logic                 ovalid_r, ovalid_nxt;

  logic [CIW-1:0]       cnt_eff;
  logic [CIW+2:0]       cnt_pad;
  logic [1:0]           nbytes;
  logic                 go, emit, walk, row_clear, null_hit;
  logic [3:0]           col4;
  logic [2:0]           col_ty;
  logic [3:0]           fsize;

  // end status from the phase a record stops in
  function automatic logic [1:0] status_of(input phase_t p);
    logic [1:0] s;
    unique case (p)
      PH_BITMAP: s = rrd_pkg::STAT_SHORT_BMAP;
      PH_DONE:   s = rrd_pkg::STAT_OK;
      default:   s = rrd_pkg::STAT_TRUNC_FIELD;
    endcase
    status_of = s;
  endfunction

  // effective column count and bitmap length
  assign cnt_eff = (cfg.column_count > 5'(MAX_COLUMNS)) ? CIW'(MAX_COLUMNS)
                                                         : CIW'(cfg.column_count);
  assign cnt_pad = (CIW+3)'(cnt_eff) + (CIW+3)'(7);
  assign nbytes  = 2'(cnt_pad >> 3);

  // current column lookups
  assign col4     = 4'(ci_r);
  assign col_ty   = rrd_pkg::col_type(cfg.column_types, col4);
  assign fsize    = rrd_pkg::type_size(col_ty);
  assign null_hit = (ci_r < cnt_eff) && null_r[ci_r[IDXW-1:0]];
  assign ci_inc   = CIW'(ci_r + 1'b1);
  assign fbc_new  = 4'(fbc_r + 1'b1);
  assign vrem_dec = 16'(vrem_r - 1'b1);
  assign bbi_inc  = 2'(bbi_r + 1'b1);
  assign go       = !ovalid_r || out_ready;

  // little-endian byte insert into the field accumulator
  always_comb begin
    acc_new = acc_r;
    for (int k = 0; k < 8; k++) begin
      if (fbc_r[2:0] == 3'(k)) begin
        acc_new[8*k +: 8] = acc_r[8*k +: 8] | q_head.record_byte;
      end
    end
  end

  // main decode step
  always_comb begin
    st_nxt    = st_r;
    phase_nxt = phase_r;
    ci_nxt    = ci_r;
    fbc_nxt   = fbc_r;
    acc_nxt   = acc_r;
    null_nxt  = null_r;
    vrem_nxt  = vrem_r;
    bbi_nxt   = bbi_r;
    pre_nxt   = pre_r;
    pend_nxt  = pend_r;
    emit      = 1'b0;
    walk      = 1'b0;
    row_clear = 1'b0;
    q_pop     = 1'b0;
    res       = '0;
    ph_eff    = phase_r;
    if (phase_r == PH_FIELD && ci_r >= cnt_eff) begin
      ph_eff = PH_DONE;
    end

    if (go) begin
      unique case (st_r)
        ST_BYTE: begin
          if (q_valid && phase_r == PH_BITMAP && bbi_r >= nbytes) begin
            // bitmap already complete: run the null walk before this byte
            ci_nxt  = '0;
            pre_nxt = 1'b1;
            st_nxt  = ST_WALK;
          end else if (q_valid) begin
            q_pop     = 1'b1;
            pend_nxt  = q_head.end_of_record;
            phase_nxt = ph_eff;
            unique case (ph_eff)
              PH_BITMAP: begin
                for (int j = 0; j < MAX_COLUMNS; j++) begin
                  if ((j >> 3) == int'(bbi_r[0])) begin
                    null_nxt[j] = null_r[j] | q_head.record_byte[j & 7];
                  end
                end
                bbi_nxt = bbi_inc;
                if (bbi_inc >= nbytes) begin
                  ci_nxt = '0;
                  walk   = 1'b1;
                end
              end
              PH_FIELD: begin
                acc_nxt = acc_new;
                fbc_nxt = fbc_new;
                if (fbc_new >= fsize) begin
                  emit       = 1'b1;
                  res.column = col4;
                  case (col_ty)
                    rrd_pkg::TY_BIGINT: begin
                      res.kind  = rrd_pkg::KIND_BIGINT;
                      res.value = acc_new;
                    end
                    rrd_pkg::TY_DOUBLE: begin
                      res.kind  = rrd_pkg::KIND_DOUBLE;
                      res.value = acc_new;
                    end
                    rrd_pkg::TY_BOOL: begin
                      res.kind  = rrd_pkg::KIND_BOOL;
                      res.value = 64'(q_head.nonzero);
                    end
                    rrd_pkg::TY_VARCHAR: begin
                      res.kind  = rrd_pkg::KIND_VC_LEN;
                      res.value = 64'(acc_new[15:0]);
                    end
                    default: begin
                      res.kind  = rrd_pkg::KIND_INT;
                      res.value = {{32{acc_new[31]}}, acc_new[31:0]};
                    end
                  endcase
                  if (col_ty == rrd_pkg::TY_VARCHAR && acc_new[15:0] != 16'd0) begin
                    vrem_nxt  = acc_new[15:0];
                    phase_nxt = PH_TEXT;
                  end else begin
                    ci_nxt = ci_inc;
                    walk   = 1'b1;
                  end
                end
              end
              PH_TEXT: begin
                emit       = 1'b1;
                res.column = col4;
                res.kind   = rrd_pkg::KIND_VC_BYTE;
                res.value  = 64'(q_head.record_byte);
                vrem_nxt   = vrem_dec;
                if (vrem_dec == 16'd0) begin
                  ci_nxt = ci_inc;
                  walk   = 1'b1;
                end
              end
              default: begin
                // trailing bytes are dropped
              end
            endcase

            if (walk) begin
              pre_nxt = 1'b0;
              st_nxt  = ST_WALK;
            end else if (q_head.end_of_record) begin
              if (emit) begin
                st_nxt = ST_END;
              end else begin
                emit       = 1'b1;
                res.kind   = rrd_pkg::KIND_END;
                res.status = status_of(phase_nxt);
                res.last   = 1'b1;
                row_clear  = 1'b1;
              end
            end
          end
        end

        ST_WALK: begin
          if (null_hit) begin
            // one null result per cycle while the output is not stalled
            emit       = 1'b1;
            res.column = col4;
            res.kind   = rrd_pkg::KIND_NULL;
            ci_nxt     = ci_inc;
          end else begin
            fbc_nxt   = '0;
            acc_nxt   = '0;
            phase_nxt = (ci_r >= cnt_eff) ? PH_DONE : PH_FIELD;
            st_nxt    = ST_BYTE;
            if (!pre_r && pend_r) begin
              emit       = 1'b1;
              res.kind   = rrd_pkg::KIND_END;
              res.status = status_of(phase_nxt);
              res.last   = 1'b1;
              row_clear  = 1'b1;
            end
          end
        end

        ST_END: begin
          emit       = 1'b1;
          res.kind   = rrd_pkg::KIND_END;
          res.status = status_of(phase_r);
          res.last   = 1'b1;
          row_clear  = 1'b1;
          st_nxt     = ST_BYTE;
        end

        default: st_nxt = ST_BYTE;
      endcase
    end

    // record end returns the row state to its start
    if (row_clear) begin
      phase_nxt = PH_BITMAP;
      ci_nxt    = '0;
      fbc_nxt   = '0;
      acc_nxt   = '0;
      null_nxt  = '0;
      vrem_nxt  = '0;
      bbi_nxt   = '0;
      pre_nxt   = 1'b0;
      pend_nxt  = 1'b0;
    end
  end

  // output register
  always_comb begin
    ores_nxt   = ores_r;
    ovalid_nxt = ovalid_r;
    if (emit) begin
      ores_nxt   = res;
      ovalid_nxt = 1'b1;
    end else if (out_ready) begin
      ovalid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r     <= ST_BYTE;
      phase_r  <= PH_BITMAP;
      ci_r     <= '0;
      fbc_r    <= '0;
      acc_r    <= '0;
      null_r   <= '0;
      vrem_r   <= '0;
      bbi_r    <= '0;
      pre_r    <= 1'b0;
      pend_r   <= 1'b0;
      ovalid_r <= 1'b0;
    end else begin
      st_r     <= st_nxt;
      phase_r  <= phase_nxt;
      ci_r     <= ci_nxt;
      fbc_r    <= fbc_nxt;
      acc_r    <= acc_nxt;
      null_r   <= null_nxt;
      vrem_r   <= vrem_nxt;
      bbi_r    <= bbi_nxt;
      pre_r    <= pre_nxt;
      pend_r   <= pend_nxt;
      ovalid_r <= ovalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ores_r <= ores_nxt;
  end

  assign out_res   = ores_r;
  assign out_valid = ovalid_r;

endmodule

@@ hdl/rrd_checker.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// rrd_checker
// Port-level checks on the row record decoder, attached by bind.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module rrd_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        in_eor,
  input logic        out_valid,
  input logic        out_ready,
  input logic [2:0]  out_kind,
  input logic [63:0] out_value,
  input logic        out_last
);

  logic [3:0] open_r, open_nxt;
  logic       in_end_xfer, out_end_xfer;

  // records whose end has been taken in but not yet delivered
  assign in_end_xfer  = in_valid && in_ready && in_eor;
  assign out_end_xfer = out_valid && out_ready && out_last;

  always_comb begin
    open_nxt = open_r;
    if (in_end_xfer && !out_end_xfer) begin
      open_nxt = 4'(open_r + 1'b1);
    end else if (!in_end_xfer && out_end_xfer) begin
      open_nxt = 4'(open_r - 1'b1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      open_r <= '0;
    end else begin
      open_r <= open_nxt;
    end
  end

  `ASSERT_CLK(a_out_hold, clk, rst_n, (out_valid && !out_ready |=> out_valid && $stable(out_kind) && $stable(out_value)), "result changed while stalled")
  `ASSERT_CLK(a_end_has_record, clk, rst_n, (out_valid && out_last |-> open_r != 4'd0 && out_kind == rrd_pkg::KIND_END), "record end without an accepted last byte")
  `ASSERT_CLK_ALWAYS(a_reset_idle, clk, (!rst_n |=> !out_valid), "output valid after reset")

endmodule

bind row_record_decoder rrd_checker u_rrd_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .in_eor    (in_ch.end_of_record),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_kind  (out_ch.kind),
  .out_value (out_ch.value),
  .out_last  (out_ch.last)
);
